>>> design/qbp_pkg.sv
package qbp_pkg;

    localparam int MAX_STEPS = 64;
    localparam int FRAC_BITS = 16;
    localparam int DIM_BITS  = 12;

    localparam int COORD_W = FRAC_BITS + 1;
    localparam int STEPS_W = 7;
    localparam int SIZE_W  = DIM_BITS + 1;
    localparam int INDEX_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SCALE_W = COORD_W + SIZE_W;

    localparam logic [COORD_W-1:0] ONE_Q     = COORD_W'(1) << FRAC_BITS;
    localparam logic [SIZE_W-1:0]  DIM_MAX   = SIZE_W'(1) << DIM_BITS;
    localparam logic [STEPS_W-1:0] STEPS_MAX = STEPS_W'(MAX_STEPS);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = SIZE_W;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    localparam logic [STEPS_W-1:0] RST_STEPS  = 7'd64;
    localparam logic [SIZE_W-1:0]  RST_WIDTH  = 13'd640;
    localparam logic [SIZE_W-1:0]  RST_HEIGHT = 13'd480;

    localparam int DIV_CNT_W = 5;
    localparam int OUT_DEPTH = 16;
    localparam int OUT_PTR_W = 4;
    localparam int OUT_CNT_W = 5;

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] ctrl_x;
        logic [COORD_W-1:0] ctrl_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } t_in_item;

    typedef struct packed {
        logic [DIM_BITS-1:0] pixel_x;
        logic [DIM_BITS-1:0] pixel_y;
        logic [INDEX_W-1:0]  pixel_index;
        logic                last_point;
    } t_out_item;

    // one segment as handed from front to back
    typedef struct packed {
        logic [COORD_W-1:0]        x0;
        logic [COORD_W-1:0]        y0;
        logic [COORD_W-1:0]        x1;
        logic [COORD_W-1:0]        y1;
        logic signed [DIFF_W-1:0]  dx01;
        logic signed [DIFF_W-1:0]  dx12;
        logic signed [DIFF_W-1:0]  dy01;
        logic signed [DIFF_W-1:0]  dy12;
        logic [STEPS_W-1:0]        n;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
        logic [COORD_W-1:0]        q0;
        logic [STEPS_W-1:0]        r0;
    } t_seg;

    typedef enum logic [1:0] {
        FS_IDLE,
        FS_DIV,
        FS_PUSH
    } t_front_state;

endpackage

>>> design/quadratic_bezier_plotter_core.sv
// throughput: one pixel per cycle within a segment while the output queue has room; the
// front end takes one segment at a time: load, bit-serial divide of 1.0 by N, hand-off
// reset: synchronous, active low; queues empty, steps 64, frame 640 x 480
module quadratic_bezier_plotter_core
    import qbp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_in_item              i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_out_item             o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [STEPS_W-1:0] r_steps;
    logic [SIZE_W-1:0]  r_width;
    logic [SIZE_W-1:0]  r_height;

    logic seg_push, seg_full, seg_pop, seg_empty;
    t_seg front_seg, back_seg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps  <= RST_STEPS;
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_STEPS:        r_steps  <= i_cfg_data[STEPS_W-1:0];
                REG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_height <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    qbp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_item     (i_item),
        .i_steps    (r_steps),
        .i_width    (r_width),
        .i_height   (r_height),
        .o_seg_push (seg_push),
        .i_seg_full (seg_full),
        .o_seg      (front_seg)
    );

    qbp_seg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (seg_push),
        .o_full  (seg_full),
        .i_seg   (front_seg),
        .i_pop   (seg_pop),
        .o_empty (seg_empty),
        .o_seg   (back_seg)
    );

    qbp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg       (back_seg),
        .i_seg_empty (seg_empty),
        .o_seg_pop   (seg_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

>>> design/qbp_front.sv
module qbp_front
    import qbp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  t_in_item           i_item,
    input  logic [STEPS_W-1:0] i_steps,
    input  logic [SIZE_W-1:0]  i_width,
    input  logic [SIZE_W-1:0]  i_height,
    output logic               o_seg_push,
    input  logic               i_seg_full,
    output t_seg               o_seg
);

    t_front_state r_state, n_state;
    t_seg r_seg;
    logic [COORD_W-1:0]   r_dvd;
    logic [COORD_W-1:0]   r_quo;
    logic [STEPS_W-1:0]   r_rem;
    logic [DIV_CNT_W-1:0] r_cnt;

    logic                 take;
    logic [STEPS_W-1:0]   rem_sh;
    logic                 rem_ge;
    logic [COORD_W-1:0]   sx0, sy0, sx1, sy1, sx2, sy2;
    logic [STEPS_W-1:0]   sat_n;
    logic [SIZE_W-1:0]    sat_w, sat_h;

    function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] v);
        return (v > ONE_Q) ? ONE_Q : v;
    endfunction

    function automatic logic [SIZE_W-1:0] sat_dim(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > DIM_MAX) begin
            r = DIM_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic signed [DIFF_W-1:0] diff(input logic [COORD_W-1:0] b,
                                                       input logic [COORD_W-1:0] a);
        return $signed({1'b0, b}) - $signed({1'b0, a});
    endfunction

    assign sx0 = sat_coord(i_item.start_x);
    assign sy0 = sat_coord(i_item.start_y);
    assign sx1 = sat_coord(i_item.ctrl_x);
    assign sy1 = sat_coord(i_item.ctrl_y);
    assign sx2 = sat_coord(i_item.end_x);
    assign sy2 = sat_coord(i_item.end_y);
    assign sat_w = sat_dim(i_width);
    assign sat_h = sat_dim(i_height);

    always_comb begin
        if (i_steps == '0) begin
            sat_n = STEPS_W'(1);
        end else if (i_steps > STEPS_MAX) begin
            sat_n = STEPS_MAX;
        end else begin
            sat_n = i_steps;
        end
    end

    // restoring divide of 1.0 by n, one quotient bit a cycle
    assign rem_sh = {r_rem[STEPS_W-2:0], r_dvd[COORD_W-1]};
    assign rem_ge = (rem_sh >= r_seg.n);

    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: begin
                if (i_push) n_state = FS_DIV;
            end
            FS_DIV: begin
                if (r_cnt == '0) n_state = FS_PUSH;
            end
            FS_PUSH: begin
                if (!i_seg_full) n_state = FS_IDLE;
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        o_full     = 1'b1;
        o_seg_push = 1'b0;
        case (r_state)
            FS_IDLE: o_full = 1'b0;
            FS_DIV:  o_full = 1'b1;
            FS_PUSH: o_seg_push = !i_seg_full;
            default: o_full = 1'b1;
        endcase
    end

    assign take = i_push && !o_full;

    always_comb begin
        o_seg    = r_seg;
        o_seg.q0 = r_quo;
        o_seg.r0 = r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_seg.x0   <= sx0;
            r_seg.y0   <= sy0;
            r_seg.x1   <= sx1;
            r_seg.y1   <= sy1;
            r_seg.dx01 <= diff(sx1, sx0);
            r_seg.dx12 <= diff(sx2, sx1);
            r_seg.dy01 <= diff(sy1, sy0);
            r_seg.dy12 <= diff(sy2, sy1);
            r_seg.n    <= sat_n;
            r_seg.w    <= sat_w;
            r_seg.h    <= sat_h;
            r_seg.q0   <= '0;
            r_seg.r0   <= '0;
            r_dvd      <= ONE_Q;
            r_quo      <= '0;
            r_rem      <= '0;
            r_cnt      <= DIV_CNT_W'(COORD_W - 1);
        end else if (r_state == FS_DIV) begin
            r_dvd <= {r_dvd[COORD_W-2:0], 1'b0};
            r_quo <= {r_quo[COORD_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sh - r_seg.n : rem_sh;
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

endmodule

>>> design/qbp_seg_queue.sv
module qbp_seg_queue
    import qbp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    output logic o_full,
    input  t_seg i_seg,
    input  logic i_pop,
    output logic o_empty,
    output t_seg o_seg
);

    // two entries: the back can chew on one segment while the next waits
    t_seg r_mem [2];
    logic r_wr, r_rd;
    logic [1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_seg   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= !r_wr;
            if (do_pop)  r_rd <= !r_rd;
            r_count <= r_count + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_seg;
    end

endmodule

>>> design/qbp_back.sv
module qbp_back
    import qbp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_seg      i_seg,
    input  logic      i_seg_empty,
    output logic      o_seg_pop,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_result
);

    // step sequencer
    t_seg               r_cur;
    logic               r_busy;
    logic [STEPS_W-1:0] r_k;
    logic [COORD_W-1:0] r_t;
    logic [STEPS_W-1:0] r_r;
    logic [OUT_CNT_W-1:0] r_pending;

    logic               issue;
    logic [STEPS_W-1:0] sum_r;
    logic               carry;
    logic [COORD_W-1:0] t_new;
    logic [STEPS_W-1:0] k_new;
    logic               last_new;

    // pipeline stages
    logic r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    logic r_l0, r_l1, r_l2, r_l3, r_l4, r_l5, r_l6, r_l7;
    logic [COORD_W-1:0] r_t0, r_t1, r_t2, r_t3;
    t_seg r_s0;
    logic [SIZE_W-1:0] r_w1, r_w2, r_w3, r_w4, r_w5, r_w6, r_w7;
    logic [SIZE_W-1:0] r_h1, r_h2, r_h3, r_h4, r_h5, r_h6;
    logic [COORD_W-1:0] r_x0_1, r_x1_1, r_y0_1, r_y1_1;
    logic signed [PROD_W-1:0] r_max, r_mbx, r_may, r_mby;
    logic [COORD_W-1:0] r_ax2, r_bx2, r_ay2, r_by2;
    logic [COORD_W-1:0] r_ax3, r_ay3, r_ax4, r_ay4;
    logic signed [DIFF_W-1:0] r_dx3, r_dy3;
    logic signed [PROD_W-1:0] r_mx4, r_my4;
    logic [COORD_W-1:0] r_px5, r_py5;
    logic [SCALE_W-1:0] r_sx6, r_sy6;
    logic [DIM_BITS-1:0] r_cx7, r_cy7;

    logic [SIZE_W:0] vx6, vy6;
    logic [SIZE_W+DIM_BITS-1:0] row_base;
    t_out_item out_entry;

    // output queue
    t_out_item r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr, r_rd;
    logic [OUT_CNT_W-1:0] r_count;
    logic out_pop;

    function automatic logic signed [PROD_W-1:0] mul_t(input logic signed [DIFF_W-1:0] d,
                                                        input logic [COORD_W-1:0] t);
        return PROD_W'(d) * PROD_W'($signed({1'b0, t}));
    endfunction

    // a + floor(p / 1.0); the true value fits the coordinate width so wrap is exact
    function automatic logic [COORD_W-1:0] add_floor(input logic [COORD_W-1:0] a,
                                                      input logic signed [PROD_W-1:0] p);
        return a + p[FRAC_BITS+COORD_W-1:FRAC_BITS];
    endfunction

    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [SIZE_W:0] v,
                                                       input logic [SIZE_W-1:0] dim);
        logic [SIZE_W-1:0] r;
        r = (v >= {1'b0, dim}) ? dim - SIZE_W'(1) : v[SIZE_W-1:0];
        return r[DIM_BITS-1:0];
    endfunction

    assign o_seg_pop = !r_busy && !i_seg_empty;

    // t advances by floor(1.0/n) with the remainder carried, giving floor(k*1.0/n)
    assign sum_r    = r_r + r_cur.r0;
    assign carry    = (sum_r >= r_cur.n);
    assign t_new    = r_t + r_cur.q0 + COORD_W'(carry);
    assign k_new    = r_k + STEPS_W'(1);
    assign last_new = (k_new == r_cur.n);
    assign issue    = r_busy && (r_pending < OUT_CNT_W'(OUT_DEPTH));

    assign out_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_pending <= '0;
        end else begin
            if (o_seg_pop) begin
                r_busy <= 1'b1;
            end else if (issue && last_new) begin
                r_busy <= 1'b0;
            end
            r_pending <= r_pending + OUT_CNT_W'(issue) - OUT_CNT_W'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_seg_pop) begin
            r_cur <= i_seg;
            r_k   <= '0;
            r_t   <= '0;
            r_r   <= '0;
        end else if (issue) begin
            r_k <= k_new;
            r_t <= t_new;
            r_r <= carry ? sum_r - r_cur.n : sum_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
        end else begin
            r_v0 <= issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    assign vx6 = (SIZE_W+1)'(r_sx6 >> FRAC_BITS);
    assign vy6 = (SIZE_W+1)'(r_sy6 >> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        // stage 0: step parameter and segment
        r_t0 <= t_new;
        r_l0 <= last_new;
        r_s0 <= r_cur;
        // stage 1: first-level lerp products
        r_t1   <= r_t0;
        r_l1   <= r_l0;
        r_w1   <= r_s0.w;
        r_h1   <= r_s0.h;
        r_x0_1 <= r_s0.x0;
        r_x1_1 <= r_s0.x1;
        r_y0_1 <= r_s0.y0;
        r_y1_1 <= r_s0.y1;
        r_max  <= mul_t(r_s0.dx01, r_t0);
        r_mbx  <= mul_t(r_s0.dx12, r_t0);
        r_may  <= mul_t(r_s0.dy01, r_t0);
        r_mby  <= mul_t(r_s0.dy12, r_t0);
        // stage 2: first-level points
        r_t2  <= r_t1;
        r_l2  <= r_l1;
        r_w2  <= r_w1;
        r_h2  <= r_h1;
        r_ax2 <= add_floor(r_x0_1, r_max);
        r_bx2 <= add_floor(r_x1_1, r_mbx);
        r_ay2 <= add_floor(r_y0_1, r_may);
        r_by2 <= add_floor(r_y1_1, r_mby);
        // stage 3: second-level differences
        r_t3  <= r_t2;
        r_l3  <= r_l2;
        r_w3  <= r_w2;
        r_h3  <= r_h2;
        r_ax3 <= r_ax2;
        r_ay3 <= r_ay2;
        r_dx3 <= $signed({1'b0, r_bx2}) - $signed({1'b0, r_ax2});
        r_dy3 <= $signed({1'b0, r_by2}) - $signed({1'b0, r_ay2});
        // stage 4: second-level products
        r_l4  <= r_l3;
        r_w4  <= r_w3;
        r_h4  <= r_h3;
        r_ax4 <= r_ax3;
        r_ay4 <= r_ay3;
        r_mx4 <= mul_t(r_dx3, r_t3);
        r_my4 <= mul_t(r_dy3, r_t3);
        // stage 5: curve point
        r_l5  <= r_l4;
        r_w5  <= r_w4;
        r_h5  <= r_h4;
        r_px5 <= add_floor(r_ax4, r_mx4);
        r_py5 <= add_floor(r_ay4, r_my4);
        // stage 6: scale to frame
        r_l6  <= r_l5;
        r_w6  <= r_w5;
        r_h6  <= r_h5;
        r_sx6 <= SCALE_W'(r_px5) * SCALE_W'(r_w5);
        r_sy6 <= SCALE_W'(r_py5) * SCALE_W'(r_h5);
        // stage 7: clamp to last column and row
        r_l7  <= r_l6;
        r_w7  <= r_w6;
        r_cx7 <= clamp_dim(vx6, r_w6);
        r_cy7 <= clamp_dim(vy6, r_h6);
    end

    assign row_base = (SIZE_W+DIM_BITS)'(r_cy7) * (SIZE_W+DIM_BITS)'(r_w7);

    always_comb begin
        out_entry.pixel_x     = r_cx7;
        out_entry.pixel_y     = r_cy7;
        out_entry.pixel_index = INDEX_W'(row_base + (SIZE_W+DIM_BITS)'(r_cx7));
        out_entry.last_point  = r_l7;
    end

    // credits above keep this queue from overflowing
    assign o_empty  = (r_count == '0);
    assign o_result = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (r_v7)    r_wr <= r_wr + OUT_PTR_W'(1);
            if (out_pop) r_rd <= r_rd + OUT_PTR_W'(1);
            r_count <= r_count + OUT_CNT_W'(r_v7) - OUT_CNT_W'(out_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v7) r_mem[r_wr] <= out_entry;
    end

endmodule

>>> test/quadratic_bezier_plotter_core_test.sv
`timescale 1ns / 1ps

module quadratic_bezier_plotter_core_test;
    import qbp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
    localparam logic [COORD_W-1:0]   COORD_TOP    = '1;

    // expected pixel stream for the segments accepted so far
    class pixel_scoreboard;
        t_out_item          expected_px[$];
        int unsigned        mismatches  = 0;
        int unsigned        pixels_seen = 0;
        logic [STEPS_W-1:0] steps_reg   = RST_STEPS;
        logic [SIZE_W-1:0]  width_reg   = RST_WIDTH;
        logic [SIZE_W-1:0]  height_reg  = RST_HEIGHT;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_STEPS:        steps_reg  = data[STEPS_W-1:0];
                REG_FRAME_WIDTH:  width_reg  = data;
                REG_FRAME_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        function longint clip_coord(logic [COORD_W-1:0] v);
            return (v > ONE_Q) ? longint'(ONE_Q) : longint'(v);
        endfunction

        function longint clip_size(logic [SIZE_W-1:0] v);
            if (v == 0) return 1;
            return (v > DIM_MAX) ? longint'(DIM_MAX) : longint'(v);
        endfunction

        // arithmetic shift floors a negative product toward minus infinity
        function longint blend(longint a, longint b, longint t);
            return a + (((b - a) * t) >>> FRAC_BITS);
        endfunction

        function longint to_pixel(longint p, longint dim);
            longint v;
            v = (p * dim) >>> FRAC_BITS;
            return (v >= dim) ? dim - 1 : v;
        endfunction

        function void note_segment(t_in_item seg);
            longint    x0, y0, x1, y1, x2, y2;
            longint    n, w, h, t, cx, cy;
            t_out_item px_exp;
            x0 = clip_coord(seg.start_x);
            y0 = clip_coord(seg.start_y);
            x1 = clip_coord(seg.ctrl_x);
            y1 = clip_coord(seg.ctrl_y);
            x2 = clip_coord(seg.end_x);
            y2 = clip_coord(seg.end_y);
            n  = (steps_reg == 0) ? 1 : (steps_reg > MAX_STEPS) ? MAX_STEPS : steps_reg;
            w  = clip_size(width_reg);
            h  = clip_size(height_reg);
            for (longint k = 1; k <= n; k++) begin
                t  = (k << FRAC_BITS) / n;
                cx = to_pixel(blend(blend(x0, x1, t), blend(x1, x2, t), t), w);
                cy = to_pixel(blend(blend(y0, y1, t), blend(y1, y2, t), t), h);
                px_exp.pixel_x     = DIM_BITS'(cx);
                px_exp.pixel_y     = DIM_BITS'(cy);
                px_exp.pixel_index = INDEX_W'(cy * w + cx);
                px_exp.last_point  = (k == n);
                expected_px.push_back(px_exp);
            end
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("pixel %0d: %s", pixels_seen, msg);
        endtask

        task check_pixel(t_out_item got);
            t_out_item want;
            pixels_seen++;
            if (expected_px.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel x=%0d y=%0d",
                                          got.pixel_x, got.pixel_y));
                return;
            end
            want = expected_px.pop_front();
            if (got.pixel_x !== want.pixel_x)
                report_mismatch($sformatf("pixel_x %0d, expected %0d",
                                          got.pixel_x, want.pixel_x));
            if (got.pixel_y !== want.pixel_y)
                report_mismatch($sformatf("pixel_y %0d, expected %0d",
                                          got.pixel_y, want.pixel_y));
            if (got.pixel_index !== want.pixel_index)
                report_mismatch($sformatf("pixel_index %0d, expected %0d",
                                          got.pixel_index, want.pixel_index));
            if (got.last_point !== want.last_point)
                report_mismatch($sformatf("last_point %0b, expected %0b",
                                          got.last_point, want.last_point));
        endtask
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  push        = 1'b0;
    logic                  full;
    t_in_item              i_item      = '0;
    logic                  empty;
    logic                  pop         = 1'b0;
    t_out_item             o_result;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    bit no_idle  = 1'b0;
    bit hold_req = 1'b0;

    pixel_scoreboard sb = new;

    quadratic_bezier_plotter_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic t_in_item mk_seg(logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                        logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                        logic [COORD_W-1:0] ex, logic [COORD_W-1:0] ey);
        t_in_item seg;
        seg.start_x = sx;
        seg.start_y = sy;
        seg.ctrl_x  = cx;
        seg.ctrl_y  = cy;
        seg.end_x   = ex;
        seg.end_y   = ey;
        return seg;
    endfunction

    // mostly in range, some exact corners, some above 1.0
    function automatic logic [COORD_W-1:0] pick_coord();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return $urandom_range(0, 1) ? ONE_Q : '0;
        if (r < 25) return COORD_W'($urandom);
        return COORD_W'($urandom_range(0, 65536));
    endfunction

    function automatic t_in_item random_segment();
        logic [COORD_W-1:0] v;
        if ($urandom_range(0, 99) < 10) begin
            v = pick_coord();
            return mk_seg(v, v, v, v, v, v);
        end
        return mk_seg(pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), pick_coord(), pick_coord());
    endfunction

    // upper data bits are random, only the low seven count
    function automatic logic [CFG_DATA_W-1:0] pick_steps();
        int unsigned r;
        logic [CFG_DATA_W-1:0] d;
        r = $urandom_range(0, 99);
        d = CFG_DATA_W'($urandom);
        if (r < 8)       d[STEPS_W-1:0] = '0;
        else if (r < 16) d[STEPS_W-1:0] = STEPS_W'($urandom_range(65, 127));
        else if (r < 50) d[STEPS_W-1:0] = STEPS_W'($urandom_range(1, 8));
        else if (r < 80) d[STEPS_W-1:0] = STEPS_W'($urandom_range(9, 32));
        else             d[STEPS_W-1:0] = STEPS_W'($urandom_range(33, 64));
        return d;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_size();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return CFG_DATA_W'($urandom);
        if (r < 20) begin
            case ($urandom_range(0, 3))
                0:       return 13'd0;
                1:       return 13'd1;
                2:       return 13'd4096;
                default: return 13'h1FFF;
            endcase
        end
        if (r < 50) return CFG_DATA_W'($urandom_range(1, 64));
        return CFG_DATA_W'($urandom_range(65, 4096));
    endfunction

    // leaves push high so back-to-back transfers stay possible
    task automatic offer_segment(input t_in_item seg);
        push   <= 1'b1;
        i_item <= seg;
        do @(posedge i_clk); while (full);
        sb.note_segment(seg);
    endtask

    task automatic pause_sender();
        int unsigned gap;
        if (!no_idle && $urandom_range(0, 99) < 27) begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 5);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_phase(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            offer_segment(random_segment());
            if (i + 1 < count) pause_sender();
        end
        push <= 1'b0;
    endtask

    task automatic settle();
        while (sb.expected_px.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic program_frame(input logic [CFG_DATA_W-1:0] steps_d,
                                 input logic [CFG_DATA_W-1:0] width_d,
                                 input logic [CFG_DATA_W-1:0] height_d,
                                 input bit with_unmapped);
        write_cfg(REG_STEPS, steps_d);
        write_cfg(REG_FRAME_WIDTH, width_d);
        write_cfg(REG_FRAME_HEIGHT, height_d);
        // last, so a decode that leaks into height would show
        if (with_unmapped) write_cfg(REG_UNMAPPED, CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // result side: checks every transfer, idles at random, holds off on request
    initial begin : drain
        int hold_left;
        hold_left = 0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            @(posedge i_clk);
            if (pop && !empty) sb.check_pixel(o_result);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= no_idle || ($urandom_range(0, 99) >= 27);
            end
        end
    end

    initial begin : stimulus
        t_in_item directed[$];
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners, saturation, reversed curves and bit patterns under the reset frame
        directed = '{
            mk_seg('0, '0, '0, '0, '0, '0),
            mk_seg(ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q),
            mk_seg(COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP, COORD_TOP),
            mk_seg('0, '0, ONE_Q, '0, ONE_Q, ONE_Q),
            mk_seg(ONE_Q, ONE_Q, '0, ONE_Q, '0, '0),
            mk_seg('0, ONE_Q, ONE_Q, ONE_Q, ONE_Q, '0),
            mk_seg(17'h15555, 17'h0AAAA, 17'h0AAAA, 17'h15555, 17'h15555, 17'h0AAAA),
            mk_seg(17'h0AAAA, 17'h15555, 17'h15555, 17'h0AAAA, 17'h0AAAA, 17'h15555),
            mk_seg('0, '0, 17'h10001, 17'h18000, ONE_Q, ONE_Q),
            mk_seg(17'd1, 17'd1, 17'd0, 17'd2, 17'd1, 17'd0),
            mk_seg(17'hFFFF, 17'hFFFF, 17'hFFFF, 17'hFFFF, 17'hFFFF, 17'hFFFF),
            mk_seg(17'd12345, 17'd54321, 17'd40000, COORD_TOP, ONE_Q, ONE_Q)
        };
        // receiver stalls while the sender keeps offering, so the input backs up
        hold_req = 1'b1;
        foreach (directed[i]) offer_segment(directed[i]);
        push <= 1'b0;
        settle();

        program_frame(13'd1, 13'd1, 13'd1, 1'b0);
        run_phase(12);
        settle();
        program_frame(13'h1F80, 13'd0, 13'd0, 1'b0);
        run_phase(12);
        settle();
        program_frame(13'd64, 13'd4096, 13'd4096, 1'b0);
        run_phase(12);
        settle();
        program_frame(13'h1FFF, 13'h1FFF, 13'h1FFF, 1'b1);
        run_phase(12);
        settle();

        for (int p = 0; p < 12; p++) begin
            program_frame(pick_steps(), pick_size(), pick_size(), (p % 4) == 0);
            no_idle = (p == 5);
            run_phase(21);
            settle();
            no_idle = 1'b0;
        end

        repeat (50) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> files.f
design/qbp_pkg.sv
design/qbp_front.sv
design/qbp_seg_queue.sv
design/qbp_back.sv
design/quadratic_bezier_plotter_core.sv
test/quadratic_bezier_plotter_core_test.sv
